[rtl/owbm_pkg.sv]
`timescale 1ns / 1ps

package owbm_pkg;

	// width of all timing registers and the tick counter
	localparam int TIME_WIDTH = 10;
	localparam int LEN_WIDTH  = TIME_WIDTH + 1;

	// configuration register indexes
	localparam int CFG_INDEX_WIDTH = 3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RESET_LOW     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RECOVERY      = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_WRITE_LOW     = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_READ_LOW      = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_READ_SAMPLE   = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SLOT_TAIL     = 3'd6;

	// register reset values, cut to the register width
	localparam logic [TIME_WIDTH-1:0] RESET_LOW_DEFAULT     = TIME_WIDTH'(500);
	localparam logic [TIME_WIDTH-1:0] PRESENCE_WAIT_DEFAULT = TIME_WIDTH'(60);
	localparam logic [TIME_WIDTH-1:0] RECOVERY_DEFAULT      = TIME_WIDTH'(500);
	localparam logic [TIME_WIDTH-1:0] WRITE_LOW_DEFAULT     = TIME_WIDTH'(1);
	localparam logic [TIME_WIDTH-1:0] READ_LOW_DEFAULT      = TIME_WIDTH'(5);
	localparam logic [TIME_WIDTH-1:0] READ_SAMPLE_DEFAULT   = TIME_WIDTH'(5);
	localparam logic [TIME_WIDTH-1:0] SLOT_TAIL_DEFAULT     = TIME_WIDTH'(60);

	// command codes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RST_LOW   = 4'd1,
		PH_RST_WAIT  = 4'd2,
		PH_RST_RECOV = 4'd3,
		PH_WR_LOW    = 4'd4,
		PH_WR_TAIL   = 4'd5,
		PH_RD_LOW    = 4'd6,
		PH_RD_WAIT   = 4'd7,
		PH_RD_TAIL   = 4'd8
	} phase_t;

	typedef struct packed {
		logic [TIME_WIDTH-1:0] reset_low_ticks;
		logic [TIME_WIDTH-1:0] presence_wait_ticks;
		logic [TIME_WIDTH-1:0] recovery_ticks;
		logic [TIME_WIDTH-1:0] write_low_ticks;
		logic [TIME_WIDTH-1:0] read_low_ticks;
		logic [TIME_WIDTH-1:0] read_sample_ticks;
		logic [TIME_WIDTH-1:0] slot_tail_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] write_byte;
		logic       bus_level;
	} in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
	} out_t;

endpackage

[rtl/one_wire_bus_master.sv]
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// cfg       in         cfg_wr_en              cfg_index, cfg_wdata
// in        in         in_valid / in_ready    in_data (owbm_pkg::in_t)
// out       out        out_valid / out_ready  out_data (owbm_pkg::out_t)
//
// one tick transaction per clock cycle sustained while out_ready is high; a result is
// registered after its tick is accepted (input register, sequencer, result register)
// in_ready drops only when both the input register and the result register are full
// and out_ready is low; the sequencer state moves only when a tick reaches the result
// arst_n clears the sequencer, the handshake registers and loads the timing defaults
module one_wire_bus_master (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [owbm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [owbm_pkg::TIME_WIDTH-1:0]      cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  owbm_pkg::in_t                        in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output owbm_pkg::out_t                       out_data
);
	import owbm_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	in_t  data_s1;
	logic out_valid_q;
	out_t out_data_q;
	out_t result;
	logic out_load;
	logic step;

	owbm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// flow control between the two registers
	assign out_load = !out_valid_q || out_ready;
	assign step     = valid_s1 && out_load;
	assign in_ready = !valid_s1 || out_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	owbm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.tick   (data_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/owbm_regs.sv]
`timescale 1ns / 1ps

module owbm_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [owbm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [owbm_pkg::TIME_WIDTH-1:0]        cfg_wdata,
	output owbm_pkg::cfg_t                         cfg
);
	import owbm_pkg::*;

	cfg_t cfg_q;

	// timing register file, writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks     <= RESET_LOW_DEFAULT;
			cfg_q.presence_wait_ticks <= PRESENCE_WAIT_DEFAULT;
			cfg_q.recovery_ticks      <= RECOVERY_DEFAULT;
			cfg_q.write_low_ticks     <= WRITE_LOW_DEFAULT;
			cfg_q.read_low_ticks      <= READ_LOW_DEFAULT;
			cfg_q.read_sample_ticks   <= READ_SAMPLE_DEFAULT;
			cfg_q.slot_tail_ticks     <= SLOT_TAIL_DEFAULT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_wdata;
				CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_wdata;
				CFG_RECOVERY:      cfg_q.recovery_ticks      <= cfg_wdata;
				CFG_WRITE_LOW:     cfg_q.write_low_ticks     <= cfg_wdata;
				CFG_READ_LOW:      cfg_q.read_low_ticks      <= cfg_wdata;
				CFG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= cfg_wdata;
				CFG_SLOT_TAIL:     cfg_q.slot_tail_ticks     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/owbm_seq.sv]
`timescale 1ns / 1ps

module owbm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  owbm_pkg::in_t  tick,
	input  owbm_pkg::cfg_t cfg,
	output owbm_pkg::out_t result
);
	import owbm_pkg::*;

	phase_t                phase_q, phase_d, cur_phase;
	logic [TIME_WIDTH-1:0] tick_count_q, tick_count_d, cur_tick;
	logic [2:0]            bit_index_q, bit_index_d, cur_bit;
	logic [7:0]            shift_byte_q, shift_byte_d, cur_shift;
	logic                  presence_q, presence_d;
	logic [7:0]            received_q, received_d;
	logic                  start;
	logic [LEN_WIDTH-1:0]  phase_len;
	logic [LEN_WIDTH-1:0]  tick_next;
	logic                  last;
	logic                  drive, busy, done;

	function automatic logic [LEN_WIDTH-1:0] at_least_one(input logic [TIME_WIDTH-1:0] v);
		at_least_one = (v == '0) ? LEN_WIDTH'(1) : {1'b0, v};
	endfunction

	// command launch from idle, the launching tick is the first tick
	always_comb begin
		start     = (phase_q == PH_IDLE) && (tick.opcode != OP_NONE);
		cur_phase = phase_q;
		cur_tick  = tick_count_q;
		cur_bit   = bit_index_q;
		cur_shift = shift_byte_q;
		if (start) begin
			cur_tick = '0;
			cur_bit  = '0;
			unique case (tick.opcode)
				OP_RESET: cur_phase = PH_RST_LOW;
				OP_WRITE: begin
					cur_phase = PH_WR_LOW;
					cur_shift = tick.write_byte;
				end
				OP_READ: begin
					cur_phase = PH_RD_LOW;
					cur_shift = '0;
				end
				default: ;
			endcase
		end
	end

	// length of the current phase and end-of-phase detect
	always_comb begin
		unique case (cur_phase)
			PH_RST_LOW:   phase_len = at_least_one(cfg.reset_low_ticks);
			PH_RST_WAIT:  phase_len = {1'b0, cfg.presence_wait_ticks} + LEN_WIDTH'(1);
			PH_RST_RECOV: phase_len = at_least_one(cfg.recovery_ticks);
			PH_WR_LOW:    phase_len = at_least_one(cfg.write_low_ticks);
			PH_WR_TAIL:   phase_len = at_least_one(cfg.slot_tail_ticks);
			PH_RD_LOW:    phase_len = at_least_one(cfg.read_low_ticks);
			PH_RD_WAIT:   phase_len = {1'b0, cfg.read_sample_ticks} + LEN_WIDTH'(1);
			PH_RD_TAIL:   phase_len = at_least_one(cfg.slot_tail_ticks);
			default:      phase_len = LEN_WIDTH'(1);
		endcase
		tick_next = {1'b0, cur_tick} + LEN_WIDTH'(1);
		last      = tick_next >= phase_len;
	end

	// next state
	always_comb begin
		phase_d      = cur_phase;
		tick_count_d = cur_tick;
		bit_index_d  = cur_bit;
		shift_byte_d = cur_shift;
		presence_d   = presence_q;
		received_d   = received_q;
		if (cur_phase != PH_IDLE) begin
			if (!last) begin
				tick_count_d = tick_next[TIME_WIDTH-1:0];
			end else begin
				tick_count_d = '0;
				unique case (cur_phase)
					PH_RST_LOW: phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_d = ~tick.bus_level;
						if (!tick.bus_level && (cfg.recovery_ticks != '0)) begin
							phase_d = PH_RST_RECOV;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_RST_RECOV: phase_d = PH_IDLE;
					PH_WR_LOW:    phase_d = PH_WR_TAIL;
					PH_WR_TAIL: begin
						if (cur_bit == LAST_BIT) begin
							phase_d = PH_IDLE;
						end else begin
							bit_index_d = cur_bit + 3'd1;
							phase_d     = PH_WR_LOW;
						end
					end
					PH_RD_LOW: phase_d = PH_RD_WAIT;
					PH_RD_WAIT: begin
						shift_byte_d[cur_bit] = tick.bus_level;
						phase_d               = PH_RD_TAIL;
					end
					PH_RD_TAIL: begin
						if (cur_bit == LAST_BIT) begin
							received_d = cur_shift;
							phase_d    = PH_IDLE;
						end else begin
							bit_index_d = cur_bit + 3'd1;
							phase_d     = PH_RD_LOW;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// per-tick outputs
	always_comb begin
		busy  = cur_phase != PH_IDLE;
		drive = 1'b0;
		done  = 1'b0;
		unique case (cur_phase)
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: drive = 1'b1;
			PH_WR_TAIL: drive = ~cur_shift[cur_bit];
			default: ;
		endcase
		if (last) begin
			unique case (cur_phase)
				PH_RST_WAIT:  done = tick.bus_level || (cfg.recovery_ticks == '0);
				PH_RST_RECOV: done = 1'b1;
				PH_WR_TAIL, PH_RD_TAIL: done = cur_bit == LAST_BIT;
				default: ;
			endcase
		end
	end

	// state registers advance once per tick taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			bit_index_q  <= '0;
			shift_byte_q <= '0;
			presence_q   <= 1'b0;
			received_q   <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			tick_count_q <= tick_count_d;
			bit_index_q  <= bit_index_d;
			shift_byte_q <= shift_byte_d;
			presence_q   <= presence_d;
			received_q   <= received_d;
		end
	end

	assign result.drive_low = drive;
	assign result.busy_res  = busy;
	assign result.done_res  = done;
	assign result.presence  = presence_d;
	assign result.read_byte = received_d;

endmodule
